### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define TBSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TBSP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TBSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/tbsp_pkg.sv
// ----------------------------------------------------------------------------
// tbsp_pkg
// Constants, register codes and shared types of the triple buffer sample player.
// ----------------------------------------------------------------------------
`default_nettype none

package tbsp_pkg;

   localparam int BufferWords = 256;
   localparam int GainShift   = 12;
   localparam int NumBufs     = 3;

   localparam int BufW     = 2;
   localparam int PtrW     = $clog2(BufferWords);
   localparam int CountW   = $clog2(BufferWords + 1);
   localparam int AddrW    = $clog2(NumBufs * BufferWords);
   localparam int WordW    = 16;
   localparam int GainW    = 16;
   localparam int PlayW    = 8;
   localparam int SampleW  = 20;
   localparam int ProductW = WordW + GainW + 1;
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 32;

   localparam logic [PlayW-1:0] PlaysEndless = 8'hFF;
   localparam logic [7:0]       DecodeXor    = 8'hAA;
   localparam logic [7:0]       DecodeAdd    = 8'hD7;
   localparam logic [BufW-1:0]  LastBuf      = BufW'(NumBufs - 1);

   // register index, taken from the word address
   typedef enum logic [1:0] {
      CsrGain           = 2'd0,
      CsrCountedMode    = 2'd1,
      CsrPlayCountStart = 2'd2
   } csr_index_type;

   // status fields of one result transaction
   typedef struct packed {
      logic                sample_valid;
      logic [NumBufs-1:0]  ready_mask;
      logic [BufW-1:0]     current_buffer;
      logic                muted;
      logic                fill_dropped;
   } rsp_status_type;

   function automatic logic [BufW-1:0] next_buf(input logic [BufW-1:0] b);
      logic [BufW-1:0] n;
      n = (b == LastBuf) ? '0 : b + BufW'(1);
      return n;
   endfunction

endpackage

`default_nettype wire

### src/tbsp_sample_ram.sv
// ----------------------------------------------------------------------------
// tbsp_sample_ram
// Sample store for all three buffers: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tbsp_sample_ram
   import tbsp_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WordW-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WordW-1:0] rd_data
);

   logic [WordW-1:0] store_mem [NumBufs * BufferWords];
   logic [WordW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/tbsp_scale.sv
// ----------------------------------------------------------------------------
// tbsp_scale
// Descramble one stored word, scale it by the gain and saturate to 20 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tbsp_scale
   import tbsp_pkg::*;
(
   input  logic                      [WordW-1:0]   word,
   input  logic                      [GainW-1:0]   gain,
   output logic signed               [SampleW-1:0] sample
);

   localparam logic signed [ProductW-1:0] SatMax = ProductW'((1 << (SampleW - 1)) - 1);
   localparam logic signed [ProductW-1:0] SatMin = ~SatMax;

   logic [WordW-1:0]           decoded;
   logic signed [ProductW-1:0] product_s;
   logic signed [ProductW-1:0] shifted_s;

   // high byte unscrambled by xor, low byte by an add modulo 256
   assign decoded = {word[15:8] ^ DecodeXor, word[7:0] + DecodeAdd};

   assign product_s = $signed({{(ProductW - WordW){decoded[WordW-1]}}, decoded})
                    * $signed({{(ProductW - GainW){1'b0}}, gain});

   // arithmetic shift floors toward minus infinity
   assign shifted_s = product_s >>> GainShift;

   always_comb begin
      if (shifted_s > SatMax) begin
         sample = SampleW'(SatMax);
      end else if (shifted_s < SatMin) begin
         sample = SampleW'(SatMin);
      end else begin
         sample = shifted_s[SampleW-1:0];
      end
   end

endmodule

`default_nettype wire

### src/triple_buffer_sample_player.sv
// ----------------------------------------------------------------------------
// triple_buffer_sample_player
// One sound channel playing descrambled words from three rotating buffers.
// ----------------------------------------------------------------------------
//
//   channel   direction   ports                    moves
//   req       in          req_valid / req_ready    one tick or fill word
//   rsp       out         rsp_valid / rsp_ready    one result per request
//   csr       in          csr_psel / csr_penable   gain, mode, play count
//
// One request transaction can be taken every cycle while the rsp side is not
// stalled. Its result is registered in stage 1 (state update and store read),
// then in stage 2 (scale into rsp regs), where it can be taken.
// Stage 2 does the scaling since the sample store has a registered read port.
// Reset is synchronous and clears all control state; the store is not cleared.
// A stalled rsp side holds its register; stage 1 keeps taking requests until
// it is full too, then req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module triple_buffer_sample_player
   import tbsp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic [WordW-1:0]           req_fill_word,
   input  logic                       req_end_of_block,
   input  logic                       req_end_of_file,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SampleW-1:0]  rsp_sample,
   output logic                       rsp_sample_valid,
   output logic [NumBufs-1:0]         rsp_ready_mask,
   output logic [BufW-1:0]            rsp_current_buffer,
   output logic                       rsp_muted,
   output logic                       rsp_fill_dropped,

   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CsrAddrW-1:0]        csr_paddr,
   input  logic [CsrDataW-1:0]        csr_pwdata,
   output logic [CsrDataW-1:0]        csr_prdata,
   output logic                       csr_pready
);

   // configuration registers
   logic [GainW-1:0]   gain_ff;
   logic               counted_mode_ff;
   logic [PlayW-1:0]   play_count_start_ff;
   logic               csr_write;

   // channel state
   logic [PlayW-1:0]   plays_left_ff,  plays_left_in;
   logic               mute_ff,        mute_in;
   logic [NumBufs-1:0] ready_flags_ff, ready_flags_in;
   logic [BufW-1:0]    play_buffer_ff, play_buffer_in;
   logic [PtrW-1:0]    play_pointer_ff, play_pointer_in;
   logic [BufW-1:0]    fill_buffer_ff, fill_buffer_in;
   logic               fill_active_ff, fill_active_in;
   logic [CountW-1:0]  fill_index_ff,  fill_index_in;
   logic [CountW-1:0]  word_count_ff [NumBufs];
   logic [CountW-1:0]  word_count_in [NumBufs];

   // pipeline
   logic               req_accept;
   logic               s1_advance;
   logic               out_load;
   logic               s1_valid_ff;
   rsp_status_type     s1_status_ff, status_in;
   logic               rsp_valid_ff;
   rsp_status_type     rsp_status_ff;
   logic signed [SampleW-1:0] rsp_sample_ff;

   // store ports and search
   logic               ram_wr_en;
   logic [AddrW-1:0]   ram_wr_addr;
   logic               ram_rd_en;
   logic [AddrW-1:0]   ram_rd_addr;
   logic [WordW-1:0]   ram_rd_data;
   logic signed [SampleW-1:0] scaled_sample;
   logic [BufW-1:0]    search_1, search_2;
   logic [BufW-1:0]    next_play;
   logic               target_ok;
   logic [BufW-1:0]    target_buf;
   logic [CountW-1:0]  target_idx;
   logic [CountW-1:0]  ptr_inc;
   logic               fill_dropped;
   logic               tick_valid;

   // ------------------------------------------------------------------------
   // Configuration port: always ready, write on the access phase
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff             <= '0;
         counted_mode_ff     <= 1'b0;
         play_count_start_ff <= PlaysEndless;
      end else if (csr_write) begin
         case (csr_paddr[CsrAddrW-1:2])
            CsrGain:           gain_ff             <= csr_pwdata[GainW-1:0];
            CsrCountedMode:    counted_mode_ff     <= csr_pwdata[0];
            CsrPlayCountStart: play_count_start_ff <= csr_pwdata[PlayW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CsrAddrW-1:2])
         CsrGain:           csr_prdata = CsrDataW'(gain_ff);
         CsrCountedMode:    csr_prdata = CsrDataW'(counted_mode_ff);
         CsrPlayCountStart: csr_prdata = CsrDataW'(play_count_start_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Handshake: rsp register loads when empty or drained, stage 1 advances
   // when empty or when its transaction moves on
   // ------------------------------------------------------------------------
   assign out_load   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = !s1_valid_ff || out_load;
   assign req_ready  = s1_advance;
   assign req_accept = req_valid && s1_advance;

   // candidate fill buffers, searched upward from the playing buffer
   assign search_1  = next_buf(play_buffer_ff);
   assign search_2  = next_buf(search_1);
   assign next_play = next_buf(play_buffer_ff);

   // ------------------------------------------------------------------------
   // Stage 1: update channel state and drive the store
   // ------------------------------------------------------------------------
   always_comb begin
      plays_left_in   = plays_left_ff;
      mute_in         = mute_ff;
      ready_flags_in  = ready_flags_ff;
      play_buffer_in  = play_buffer_ff;
      play_pointer_in = play_pointer_ff;
      fill_buffer_in  = fill_buffer_ff;
      fill_active_in  = fill_active_ff;
      fill_index_in   = fill_index_ff;
      word_count_in   = word_count_ff;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      fill_dropped    = 1'b0;
      tick_valid      = 1'b0;
      target_ok       = fill_active_ff;
      target_buf      = fill_buffer_ff;
      target_idx      = fill_index_ff;
      ptr_inc         = CountW'(play_pointer_ff) + CountW'(1);

      // a new block takes the first buffer that is not ready
      if (!fill_active_ff) begin
         target_idx = '0;
         if (!ready_flags_ff[play_buffer_ff]) begin
            target_ok  = 1'b1;
            target_buf = play_buffer_ff;
         end else if (!ready_flags_ff[search_1]) begin
            target_ok  = 1'b1;
            target_buf = search_1;
         end else if (!ready_flags_ff[search_2]) begin
            target_ok  = 1'b1;
            target_buf = search_2;
         end
      end

      ram_wr_addr = AddrW'(target_buf) * AddrW'(BufferWords)
                  + AddrW'(target_idx[PtrW-1:0]);
      ram_rd_addr = AddrW'(play_buffer_ff) * AddrW'(BufferWords)
                  + AddrW'(play_pointer_ff);

      if (req_accept) begin
         if (req_func) begin
            if (!target_ok) begin
               // every buffer full: drop, ignore the block flags
               fill_dropped = 1'b1;
            end else begin
               fill_active_in = 1'b1;
               fill_buffer_in = target_buf;
               fill_index_in  = target_idx;
               if (target_idx < CountW'(BufferWords)) begin
                  ram_wr_en     = 1'b1;
                  fill_index_in = target_idx + CountW'(1);
               end else begin
                  // overflow: drop the word, keep the block going
                  fill_dropped = 1'b1;
               end
               if (req_end_of_block) begin
                  word_count_in[target_buf]  = fill_index_in;
                  ready_flags_in[target_buf] = 1'b1;
                  fill_active_in             = 1'b0;
                  if (req_end_of_file && counted_mode_ff &&
                      plays_left_ff != PlaysEndless) begin
                     plays_left_in = plays_left_ff - PlayW'(1);
                     if (plays_left_in == '0) begin
                        mute_in = 1'b1;
                     end
                  end
               end
            end
         end else if (gain_ff != '0 && !mute_ff && ready_flags_ff[play_buffer_ff]) begin
            ram_rd_en  = 1'b1;
            tick_valid = 1'b1;
            if (ptr_inc >= word_count_ff[play_buffer_ff]) begin
               // buffer used up: rewind, free it, move on if the next is ready
               play_pointer_in                = '0;
               ready_flags_in[play_buffer_ff] = 1'b0;
               if (ready_flags_ff[next_play]) begin
                  play_buffer_in = next_play;
               end
            end else begin
               play_pointer_in = ptr_inc[PtrW-1:0];
            end
         end
      end

      status_in.sample_valid   = tick_valid;
      status_in.ready_mask     = ready_flags_in;
      status_in.current_buffer = play_buffer_in;
      status_in.muted          = mute_in;
      status_in.fill_dropped   = fill_dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff         <= 1'b0;
         ready_flags_ff  <= '0;
         play_buffer_ff  <= '0;
         play_pointer_ff <= '0;
         fill_buffer_ff  <= '0;
         fill_active_ff  <= 1'b0;
         fill_index_ff   <= '0;
         for (int i = 0; i < NumBufs; i++) begin
            word_count_ff[i] <= '0;
         end
      end else begin
         mute_ff         <= mute_in;
         ready_flags_ff  <= ready_flags_in;
         play_buffer_ff  <= play_buffer_in;
         play_pointer_ff <= play_pointer_in;
         fill_buffer_ff  <= fill_buffer_in;
         fill_active_ff  <= fill_active_in;
         fill_index_ff   <= fill_index_in;
         word_count_ff   <= word_count_in;
      end
   end

   // a play count write reloads the remaining plays
   always_ff @(posedge clock) begin
      if (reset) begin
         plays_left_ff <= PlaysEndless;
      end else if (csr_write && csr_paddr[CsrAddrW-1:2] == CsrPlayCountStart) begin
         plays_left_ff <= csr_pwdata[PlayW-1:0];
      end else begin
         plays_left_ff <= plays_left_in;
      end
   end

   tbsp_sample_ram u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_fill_word),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s1_status_ff <= status_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: scale the stored word into the rsp register
   // ------------------------------------------------------------------------
   tbsp_scale u_scale (
      .word   (ram_rd_data),
      .gain   (gain_ff),
      .sample (scaled_sample)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= s1_status_ff;
         rsp_sample_ff <= s1_status_ff.sample_valid ? scaled_sample : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample         = rsp_sample_ff;
   assign rsp_sample_valid   = rsp_status_ff.sample_valid;
   assign rsp_ready_mask     = rsp_status_ff.ready_mask;
   assign rsp_current_buffer = rsp_status_ff.current_buffer;
   assign rsp_muted          = rsp_status_ff.muted;
   assign rsp_fill_dropped   = rsp_status_ff.fill_dropped;

endmodule

`default_nettype wire

### src/tbsp_checker.sv
// ----------------------------------------------------------------------------
// tbsp_checker
// Port-level checks of the sample player, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tbsp_checker
   import tbsp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [SampleW-1:0]  rsp_sample,
   input  logic                       rsp_sample_valid,
   input  logic [NumBufs-1:0]         rsp_ready_mask,
   input  logic [BufW-1:0]            rsp_current_buffer,
   input  logic                       rsp_muted,
   input  logic                       rsp_fill_dropped
);

   logic                             seen_muted_ff;
   logic [SampleW+NumBufs+BufW+2:0]  payload;
   logic                             stall;
   logic                             silent;
   logic                             played;
   logic                             blocked;
   logic                             mute_due;

   assign payload  = {rsp_sample, rsp_sample_valid, rsp_ready_mask,
                      rsp_current_buffer, rsp_muted, rsp_fill_dropped};
   assign stall    = rsp_valid && !rsp_ready;
   assign silent   = rsp_valid && !rsp_sample_valid;
   assign played   = rsp_valid && rsp_sample_valid;
   assign blocked  = rsp_muted || rsp_fill_dropped;
   assign mute_due = seen_muted_ff && rsp_valid;

   // remember that a result showed the channel muted
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_muted_ff <= 1'b0;
      end else if (rsp_valid && rsp_muted) begin
         seen_muted_ff <= 1'b1;
      end
   end

   `TBSP_ASSERT_NEXT(a_hold, clock, reset, stall, rsp_valid && $stable(payload), "rsp moved")
   `TBSP_ASSERT_IMPLY(a_silent, clock, reset, silent, rsp_sample == '0, "nonzero silent sample")
   `TBSP_ASSERT_IMPLY(a_tick_clean, clock, reset, played, !blocked, "played while blocked")
   `TBSP_ASSERT_IMPLY(a_mute_sticky, clock, reset, mute_due, rsp_muted, "mute released")

endmodule

bind triple_buffer_sample_player tbsp_checker u_tbsp_checker (.*);

`default_nettype wire

### tb/sv/tb_player_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// tb_player_scoreboard_pkg
// Scoreboard of the triple buffer sample player: predicts the result of each
// request transaction and checks the result transactions against it.
// ----------------------------------------------------------------------------
package tb_player_scoreboard_pkg;

   import tbsp_pkg::*;

   typedef struct packed {
      logic signed [SampleW-1:0] sample;
      rsp_status_type            status;
   } player_result_type;

   class player_scoreboard;

      logic [GainW-1:0]   gain;
      logic               counted_mode;
      logic [PlayW-1:0]   play_count_start;

      logic [WordW-1:0]   sample_mem [NumBufs*BufferWords];
      logic [CountW-1:0]  words_held [NumBufs];
      logic [NumBufs-1:0] ready_flags;
      logic [BufW-1:0]    play_buf;
      logic [CountW-1:0]  play_ptr;
      logic [BufW-1:0]    fill_buf;
      logic               fill_open;
      logic [CountW-1:0]  fill_idx;
      logic [PlayW-1:0]   plays_left;
      logic               mute_flag;

      player_result_type results_due[$];

      int mismatches;
      int checked;
      int decoded;
      int dropped;
      int overflowed;
      int files_ended;

      function new();
         gain             = '0;
         counted_mode     = 1'b0;
         play_count_start = PlaysEndless;
         plays_left       = PlaysEndless;
         foreach (sample_mem[i]) sample_mem[i] = '0;
         foreach (words_held[i]) words_held[i] = '0;
         ready_flags = '0;
         play_buf    = '0;
         play_ptr    = '0;
         fill_buf    = '0;
         fill_open   = 1'b0;
         fill_idx    = '0;
         mute_flag   = 1'b0;
         mismatches  = 0;
         checked     = 0;
         decoded     = 0;
         dropped     = 0;
         overflowed  = 0;
         files_ended = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CsrDataW-1:0] value);
         case (idx)
            CsrGain: begin
               gain = value[GainW-1:0];
            end
            CsrCountedMode: begin
               counted_mode = value[0];
            end
            CsrPlayCountStart: begin
               // a new start count reloads the remaining plays
               play_count_start = value[PlayW-1:0];
               plays_left       = value[PlayW-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // descramble one stored word, scale by the gain, floor and saturate
      function logic signed [SampleW-1:0] scaled_sample(logic [WordW-1:0] word);
         logic [7:0]         hi;
         logic [7:0]         lo;
         logic signed [15:0] level;
         longint             product;
         longint             top;
         longint             bottom;
         hi      = word[15:8] ^ DecodeXor;
         lo      = word[7:0] + DecodeAdd;
         level   = {hi, lo};
         product = longint'(level) * longint'(gain);
         product = product >>> GainShift;
         top     = (longint'(1) <<< (SampleW - 1)) - 1;
         bottom  = -(longint'(1) <<< (SampleW - 1));
         if (product > top) product = top;
         if (product < bottom) product = bottom;
         return SampleW'(product);
      endfunction

      function void note_request(logic func, logic [WordW-1:0] word, logic eob, logic eof);
         player_result_type r;
         logic [BufW-1:0]   b;
         bit                have_buf;
         int                k;
         int                next_ptr;
         r = '0;
         if (func) begin
            // open a block in the first buffer not ready, from the play buffer on
            have_buf = fill_open;
            for (k = 0; k < NumBufs && !have_buf; k++) begin
               b = BufW'((int'(play_buf) + k) % NumBufs);
               if (!ready_flags[b]) begin
                  fill_buf  = b;
                  fill_idx  = '0;
                  fill_open = 1'b1;
                  have_buf  = 1'b1;
               end
            end
            if (!have_buf) begin
               r.status.fill_dropped = 1'b1;
               dropped++;
            end else begin
               if (fill_idx < BufferWords) begin
                  sample_mem[int'(fill_buf) * BufferWords + int'(fill_idx)] = word;
                  fill_idx++;
               end else begin
                  r.status.fill_dropped = 1'b1;
                  dropped++;
                  overflowed++;
               end
               if (eob) begin
                  words_held[fill_buf]  = fill_idx;
                  ready_flags[fill_buf] = 1'b1;
                  fill_open             = 1'b0;
                  if (eof) files_ended++;
                  if (eof && counted_mode && plays_left != PlaysEndless) begin
                     plays_left = plays_left - 1'b1;
                     if (plays_left == '0) mute_flag = 1'b1;
                  end
               end
            end
         end else if (gain != '0 && !mute_flag && ready_flags[play_buf]) begin
            r.sample              = scaled_sample(
               sample_mem[int'(play_buf) * BufferWords + int'(play_ptr)]);
            r.status.sample_valid = 1'b1;
            decoded++;
            next_ptr = int'(play_ptr) + 1;
            if (next_ptr >= int'(words_held[play_buf])) begin
               // buffer used up: free it and move on if the next one is ready
               b                     = BufW'((int'(play_buf) + 1) % NumBufs);
               next_ptr              = 0;
               ready_flags[play_buf] = 1'b0;
               if (ready_flags[b]) play_buf = b;
            end
            play_ptr = CountW'(next_ptr);
         end
         r.status.ready_mask     = ready_flags;
         r.status.current_buffer = play_buf;
         r.status.muted          = mute_flag;
         results_due.push_back(r);
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      function void check_result(logic signed [SampleW-1:0] sample, rsp_status_type got);
         player_result_type want;
         checked++;
         if (results_due.size() == 0) begin
            mismatches++;
            $error("result transaction with no request outstanding");
            return;
         end
         want = results_due.pop_front();
         compare_field("sample", $signed(want.sample), $signed(sample));
         compare_field("sample_valid", want.status.sample_valid, got.sample_valid);
         compare_field("ready_mask", want.status.ready_mask, got.ready_mask);
         compare_field("current_buffer", want.status.current_buffer, got.current_buffer);
         compare_field("muted", want.status.muted, got.muted);
         compare_field("fill_dropped", want.status.fill_dropped, got.fill_dropped);
      endfunction

   endclass

endpackage

### tb/sv/tb_triple_buffer_sample_player.sv
// ----------------------------------------------------------------------------
// tb_triple_buffer_sample_player
// Drives tick and fill transactions through the sample player under several
// gain, mode and play-count settings and checks every result transaction
// against a scoreboard that tracks the three buffers, play and mute state.
// ----------------------------------------------------------------------------
module tb_triple_buffer_sample_player;

   import tbsp_pkg::*;
   import tb_player_scoreboard_pkg::*;

   // fill words that descramble to the two ends of the signed 16-bit range
   localparam logic [WordW-1:0] WordMostNegative = 16'h2A29;
   localparam logic [WordW-1:0] WordMostPositive = 16'hD528;

   localparam logic FuncTick = 1'b0;
   localparam logic FuncFill = 1'b1;

   typedef enum logic [1:0] {
      StallNone,
      StallCoin,
      StallHeavy,
      StallLight
   } stall_pattern_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   logic                      req_func         = 1'b0;
   logic [WordW-1:0]          req_fill_word    = '0;
   logic                      req_end_of_block = 1'b0;
   logic                      req_end_of_file  = 1'b0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [SampleW-1:0] rsp_sample;
   logic                      rsp_sample_valid;
   logic [NumBufs-1:0]        rsp_ready_mask;
   logic [BufW-1:0]           rsp_current_buffer;
   logic                      rsp_muted;
   logic                      rsp_fill_dropped;

   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CsrAddrW-1:0]       csr_paddr   = '0;
   logic [CsrDataW-1:0]       csr_pwdata  = '0;
   logic [CsrDataW-1:0]       csr_prdata;
   logic                      csr_pready;

   player_scoreboard scoreboard = new();

   int items_sent     = 0;
   int burst_left     = 0;
   int csr_errors     = 0;
   int settings_used  = 0;

   stall_pattern_type stall_pattern = StallNone;
   int                pattern_left  = 0;
   logic [1:0]        stall_phase   = '0;

   triple_buffer_sample_player dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_fill_word      (req_fill_word),
      .req_end_of_block   (req_end_of_block),
      .req_end_of_file    (req_end_of_file),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sample         (rsp_sample),
      .rsp_sample_valid   (rsp_sample_valid),
      .rsp_ready_mask     (rsp_ready_mask),
      .rsp_current_buffer (rsp_current_buffer),
      .rsp_muted          (rsp_muted),
      .rsp_fill_dropped   (rsp_fill_dropped),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #5 clock = ~clock;

   // Hard stop in case a handshake never completes.
   initial begin
      #2_000_000;
      $display("triple_buffer_sample_player test failed");
      $finish;
   end

   // Receiver: switch between stall patterns at random so that
   // back-pressure hits every pipeline phase, with stretches of none at all.
   always @(posedge clock) begin
      if (pattern_left == 0) begin
         stall_pattern = stall_pattern_type'($urandom_range(0, 3));
         pattern_left  = $urandom_range(30, 200);
      end else begin
         pattern_left--;
      end
      stall_phase++;
      case (stall_pattern)
         StallNone:  rsp_ready <= 1'b1;
         StallCoin:  rsp_ready <= 1'($urandom_range(0, 1));
         StallHeavy: rsp_ready <= (stall_phase == 2'd0);
         default:    rsp_ready <= ($urandom_range(0, 5) != 0);
      endcase
   end

   // Monitor: sample both handshakes with pre-edge values. Note the request
   // first so a result taken with its request would still find its expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            scoreboard.note_request(req_func, req_fill_word, req_end_of_block,
                                    req_end_of_file);
         if (rsp_valid && rsp_ready)
            scoreboard.check_result(rsp_sample,
                                    rsp_status_type'{rsp_sample_valid, rsp_ready_mask,
                                                     rsp_current_buffer, rsp_muted,
                                                     rsp_fill_dropped});
      end
   end

   // Send one request transaction. The sender works in bursts: when a burst
   // runs out, drop valid for a random gap (sometimes none) before the next.
   task automatic send_item(input logic func, input logic [WordW-1:0] word,
                            input logic eob, input logic eof);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_func         <= func;
      req_fill_word    <= word;
      req_end_of_block <= eob;
      req_end_of_file  <= eof;
      // hold the payload until the transaction is taken
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_tick();
      // tick ignores the fill fields, so fill them with noise
      send_item(FuncTick, 16'($urandom), 1'($urandom), 1'($urandom));
   endtask

   function automatic logic [WordW-1:0] pick_word();
      logic [WordW-1:0] w;
      case ($urandom_range(0, 15))
         0:       w = '0;
         1:       w = '1;
         2:       w = WordMostNegative;
         3:       w = WordMostPositive;
         default: w = 16'($urandom);
      endcase
      return w;
   endfunction

   // One well-formed block: end of block on the last word only.
   task automatic send_block(input int len, input logic eof);
      int i;
      for (i = 0; i < len; i++)
         send_item(FuncFill, pick_word(), i == len - 1, (i == len - 1) ? eof : 1'b0);
   endtask

   // Let every outstanding result drain before touching a register. First let
   // the monitor note the last accepted request.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write (setup + access), then read the register back the same way.
   task automatic set_register(input csr_index_type idx, input logic [CsrDataW-1:0] value);
      logic [CsrDataW-1:0] readback;
      scoreboard.write_register(idx, value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // write lands at this edge; start the read setup
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== value) begin
         csr_errors++;
         $error("register %s: expected %0h, got %0h", idx.name(), value, readback);
      end
   endtask

   task automatic run_directed();
      // gain still at zero: ticks stay silent, even over a ready buffer
      send_tick();
      send_item(FuncFill, 16'h0000, 1'b1, 1'b0);
      send_tick();
      drain();
      set_register(CsrGain, 32'h0000_FFFF);
      settings_used++;
      // fill the other two buffers, then one more fill with none free
      send_item(FuncFill, 16'hFFFF, 1'b1, 1'b0);
      send_item(FuncFill, WordMostNegative, 1'b1, 1'b0);
      send_item(FuncFill, 16'h1234, 1'b1, 1'b1);
      // play all three, rotating, then one tick over an empty buffer
      repeat (4) send_tick();
      send_item(FuncFill, WordMostPositive, 1'b1, 1'b0);
      send_tick();
      drain();
      // smallest gain, counted mode with no plays left: end of file wraps
      set_register(CsrGain, 32'h0000_0001);
      set_register(CsrCountedMode, 32'h0000_0001);
      set_register(CsrPlayCountStart, 32'h0000_0000);
      settings_used++;
      send_item(FuncFill, 16'h5555, 1'b0, 1'b1);
      send_item(FuncFill, 16'hAAAA, 1'b1, 1'b1);
      repeat (3) send_tick();
   endtask

   // Random traffic: mostly whole blocks and runs of ticks so buffers keep
   // cycling, plus single noise transactions with every field random.
   task automatic run_random(input int count);
      int target;
      int pick;
      int len;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 42) begin
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(240, 270)
                                               : $urandom_range(1, 10);
            send_block(len, $urandom_range(0, 2) == 0);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 24)) send_tick();
         end else begin
            send_item(1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
         end
      end
   endtask

   task automatic run_phase(input logic [GainW-1:0] gain, input logic counted,
                            input logic [PlayW-1:0] plays, input int count);
      drain();
      set_register(CsrGain, CsrDataW'(gain));
      set_register(CsrCountedMode, CsrDataW'(counted));
      set_register(CsrPlayCountStart, CsrDataW'(plays));
      settings_used++;
      run_random(count);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // full gain, plain mode; open with a block that overruns its buffer
      drain();
      set_register(CsrGain, 32'h0000_FFFF);
      set_register(CsrCountedMode, 32'h0000_0000);
      set_register(CsrPlayCountStart, 32'h0000_00FF);
      settings_used++;
      send_block(260, 1'b1);
      run_random(180);

      // counted mode with the endless count, then with the count at zero
      run_phase(16'($urandom_range(1, 16'hFFFF)), 1'b1, PlaysEndless, 200);
      run_phase(16'h1000, 1'b1, 8'h00, 200);
      // silenced by gain: buffers fill up and fills get dropped
      run_phase(16'h0000, 1'b0, PlaysEndless, 60);
      run_phase(16'($urandom_range(1, 16'hFFFF)), 1'b1,
                8'($urandom_range(100, 254)), 200);
      // last: few plays left, so the channel mutes and stays muted
      run_phase(16'($urandom_range(1, 16'hFFFF)), 1'b1, 8'd3, 120);

      drain();
      repeat (8) @(posedge clock);

      $display("Ran %0d transactions over %0d register settings: %0d decoded samples,",
               scoreboard.checked, settings_used, scoreboard.decoded);
      $display("%0d dropped fill words (%0d past a full buffer), %0d file ends, channel %s.",
               scoreboard.dropped, scoreboard.overflowed, scoreboard.files_ended,
               scoreboard.mute_flag ? "muted" : "playing");
      if (scoreboard.mismatches == 0 && csr_errors == 0 && scoreboard.pending() == 0) begin
         $display("triple_buffer_sample_player test passed");
      end else begin
         $display("triple_buffer_sample_player test failed");
      end
      $finish;
   end

endmodule
